>>> src/bbse_pkg.sv
// ----------------------------------------------------------------------------
// bbse_pkg
// Shared types, constants and the character check for the block extractor.
// ----------------------------------------------------------------------------
package bbse_pkg;

  // key value after reset (plus-shaped key for a 3x3 block)
  localparam int unsigned KeyReset = 186;

  // depth of the queue between front and back, and of the result queue
  localparam int unsigned QueueDepth = 2;

  // end cause codes
  localparam logic EndCauseInvalid   = 1'b0;
  localparam logic EndCauseExhausted = 1'b1;

  // allowed character set bounds
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChBang  = 8'd33;
  localparam logic [7:0] ChComma = 8'd44;
  localparam logic [7:0] ChDot   = 8'd46;
  localparam logic [7:0] ChQuest = 8'd63;
  localparam logic [7:0] ChDig0  = 8'd48;
  localparam logic [7:0] ChDig9  = 8'd57;
  localparam logic [7:0] ChUpA   = 8'd65;
  localparam logic [7:0] ChUpZ   = 8'd90;
  localparam logic [7:0] ChLoA   = 8'd97;
  localparam logic [7:0] ChLoZ   = 8'd122;

  // classified block, front to back
  typedef struct packed {
    logic has_bit;
    logic data_bit;
    logic first;
    logic last;
  } cls_t;

  // one result item
  typedef struct packed {
    logic [7:0] char_value;
    logic       char_valid;
    logic       message_end;
    logic       end_cause;
  } res_t;

  function automatic logic char_allowed(input logic [7:0] c);
    logic ok;
    ok = (c == ChSpace) || (c == ChBang) || (c == ChComma) ||
         (c == ChDot) || (c == ChQuest) ||
         ((c >= ChDig0) && (c <= ChDig9)) ||
         ((c >= ChUpA) && (c <= ChUpZ)) ||
         ((c >= ChLoA) && (c <= ChLoZ));
    return ok;
  endfunction

endpackage

>>> src/binary_block_stego_extractor_core.sv
// ----------------------------------------------------------------------------
// binary_block_stego_extractor_core
// Recovers a hidden text message from the blocks of a binary image.
// ----------------------------------------------------------------------------
// One block is taken per clock cycle and, with no stall on the result side,
// results keep pace at one per cycle. The front stage counts the keyed pixels
// of a block and classifies it in the cycle it is pushed; the classified item
// waits in a two-entry queue, and the back stage, which holds the byte under
// assembly, takes one item per cycle while the result queue has room and
// writes any result into a two-entry result queue. A result reaches the
// outputs once the back stage has written it into the result queue, and it
// stays there until popped. The key may be written only while the block is idle.
module binary_block_stego_extractor_core
  import bbse_pkg::*;
#(
  parameter int unsigned BLOCK_DIM = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [BLOCK_DIM*BLOCK_DIM-1:0] key_mask_i,
  input  logic                           push,
  output logic                           full,
  input  logic [BLOCK_DIM*BLOCK_DIM-1:0] block_bits_i,
  input  logic                           first_block_i,
  input  logic                           last_block_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     char_value_o,
  output logic                           char_valid_o,
  output logic                           message_end_o,
  output logic                           end_cause_o
);

  localparam int unsigned Cells = BLOCK_DIM * BLOCK_DIM;

  cls_t cls_in, cls_out;
  logic cls_empty, cls_pop;
  res_t res_in, res_out;
  logic res_full, res_push;

  assign cfg_ready_o = 1'b1;

  bbse_front #(
    .Cells(Cells)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_key_i    (key_mask_i),
    .block_bits_i (block_bits_i),
    .first_block_i(first_block_i),
    .last_block_i (last_block_i),
    .cls_o        (cls_in)
  );

  bbse_fifo #(
    .Width($bits(cls_t)),
    .Depth(QueueDepth)
  ) u_cls_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (push),
    .wr_data_i(cls_in),
    .rd_en_i  (cls_pop),
    .rd_data_o(cls_out),
    .full_o   (full),
    .empty_o  (cls_empty)
  );

  bbse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cls_empty_i(cls_empty),
    .cls_i      (cls_out),
    .cls_pop_o  (cls_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // every result transaction leaves through this queue
  bbse_fifo #(
    .Width($bits(res_t)),
    .Depth(QueueDepth)
  ) u_res_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (res_push),
    .wr_data_i(res_in),
    .rd_en_i  (pop),
    .rd_data_o(res_out),
    .full_o   (res_full),
    .empty_o  (empty)
  );

  assign char_value_o  = res_out.char_value;
  assign char_valid_o  = res_out.char_valid;
  assign message_end_o = res_out.message_end;
  assign end_cause_o   = res_out.end_cause;

endmodule

>>> src/bbse_fifo.sv
// ----------------------------------------------------------------------------
// bbse_fifo
// Small register queue with a write port and a read port.
// ----------------------------------------------------------------------------
module bbse_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> src/bbse_front.sv
// ----------------------------------------------------------------------------
// bbse_front
// Holds the key, counts keyed pixels of a block and classifies it.
// ----------------------------------------------------------------------------
module bbse_front
  import bbse_pkg::*;
#(
  parameter int unsigned Cells = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [Cells-1:0] cfg_key_i,
  input  logic [Cells-1:0] block_bits_i,
  input  logic             first_block_i,
  input  logic             last_block_i,
  output cls_t             cls_o
);

  localparam int unsigned CntW = $clog2(Cells + 1);

  logic [Cells-1:0] key_q;
  logic [Cells-1:0] hits;
  logic [CntW-1:0]  hit_cnt;
  logic [CntW-1:0]  key_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= Cells'(KeyReset);
    end else if (cfg_we_i) begin
      key_q <= cfg_key_i;
    end
  end

  assign hits = block_bits_i & key_q;

  always_comb begin
    hit_cnt = '0;
    key_cnt = '0;
    for (int i = 0; i < Cells; i++) begin
      hit_cnt = hit_cnt + CntW'(hits[i]);
      key_cnt = key_cnt + CntW'(key_q[i]);
    end
  end

  always_comb begin
    cls_o.has_bit  = (hit_cnt != '0) && (hit_cnt < key_cnt);
    cls_o.data_bit = hit_cnt[0];
    cls_o.first    = first_block_i;
    cls_o.last     = last_block_i;
  end

endmodule

>>> src/bbse_back.sv
// ----------------------------------------------------------------------------
// bbse_back
// Assembles carried bits into bytes, checks them and builds result items.
// ----------------------------------------------------------------------------
module bbse_back
  import bbse_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cls_empty_i,
  input  cls_t cls_i,
  output logic cls_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  logic [7:0] byte_q, byte_d;
  logic [2:0] bits_q, bits_d;
  logic       stop_q, stop_d;
  logic [7:0] sh;
  logic [7:0] chv;
  logic       cvalid;
  logic       take;

  assign take      = !cls_empty_i && !res_full_i;
  assign cls_pop_o = take;

  always_comb begin
    byte_d     = byte_q;
    bits_d     = bits_q;
    stop_d     = stop_q;
    res_push_o = 1'b0;
    res_o      = '0;
    chv        = '0;
    cvalid     = 1'b0;
    sh         = '0;
    if (take) begin
      // a first block clears everything before its bit is used
      if (cls_i.first) begin
        byte_d = '0;
        bits_d = '0;
        stop_d = 1'b0;
      end
      if (!stop_d) begin
        if (cls_i.has_bit) begin
          sh     = {byte_d[6:0], cls_i.data_bit};
          byte_d = sh;
          bits_d = bits_d + 3'd1;
          if (bits_d == 3'd0) begin
            byte_d = '0;
            if (char_allowed(sh)) begin
              chv    = sh;
              cvalid = 1'b1;
            end else begin
              stop_d            = 1'b1;
              res_push_o        = 1'b1;
              res_o.message_end = 1'b1;
              res_o.end_cause   = EndCauseInvalid;
            end
          end
        end
        // an invalid byte already ended the message
        if (!stop_d) begin
          if (cls_i.last) begin
            byte_d            = '0;
            bits_d            = '0;
            stop_d            = 1'b1;
            res_push_o        = 1'b1;
            res_o.char_value  = chv;
            res_o.char_valid  = cvalid;
            res_o.message_end = 1'b1;
            res_o.end_cause   = EndCauseExhausted;
          end else if (cvalid) begin
            res_push_o       = 1'b1;
            res_o.char_value = chv;
            res_o.char_valid = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
      bits_q <= '0;
      stop_q <= 1'b0;
    end else begin
      byte_q <= byte_d;
      bits_q <= bits_d;
      stop_q <= stop_d;
    end
  end

endmodule
